// File: rtl/cfr_pkg.sv
// Shared types, codes and helpers for the clock frame replacement block.
`default_nettype none

package cfr_pkg;

  // Defaults for the top-level parameters.
  localparam int FRAMES_DEF   = 64;
  localparam int TAG_BITS_DEF = 20;

  // The frame slot field is six bits wide, so no more than this many slots exist.
  localparam int MAX_SLOTS = 64;

  // Slots examined per cycle by the free-slot scan.
  localparam int CHUNK = 8;

  // Fixed field widths of the streams and the limit register.
  localparam int OP_W     = 3;
  localparam int SLOT_W_IO = 6;
  localparam int TAG_W_IO = 20;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int ACTION_W = 2;
  localparam int LIMIT_W  = 7;
  localparam int DATA_W   = 32;

  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 7'd64;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC  = 3'd0,
    OP_FREE   = 3'd1,
    OP_PIN    = 3'd2,
    OP_UNPIN  = 3'd3,
    OP_ACCESS = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_NO_VICTIM   = 2'd1,
    STAT_NOT_USED    = 2'd2,
    STAT_UNPIN_ZERO  = 2'd3
  } status_e;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE       = 2'd0,
    ACT_WRITE_BACK = 2'd1,
    ACT_DISCARD    = 2'd2,
    ACT_SWAP_OUT   = 2'd3
  } action_e;

  localparam logic [KIND_W-1:0] KIND_FILE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MMAP = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MODIFY,
    ST_SCAN,
    ST_SW_RD,
    ST_SW_EV
  } state_e;

  // Result of one chunk of the free-slot scan.
  typedef struct packed {
    logic       found;
    logic [2:0] pos;
  } scan_res_t;

  // One result beat before packing.
  typedef struct packed {
    status_e                 status;
    logic [SLOT_W_IO-1:0]    granted_slot;
    logic                    evicted;
    logic [TAG_W_IO-1:0]     evicted_page;
    action_e                 evict_action;
  } result_t;

  // What has to happen to a page that loses its frame.
  function automatic action_e evict_action_f(logic [KIND_W-1:0] kind, logic dirty);
    action_e act;
    if (kind == KIND_MMAP) begin
      act = dirty ? ACT_WRITE_BACK : ACT_NONE;
    end else if (kind == KIND_FILE && !dirty) begin
      act = ACT_DISCARD;
    end else begin
      act = ACT_SWAP_OUT;
    end
    return act;
  endfunction

  function automatic logic [DATA_W-1:0] pack_result(result_t r);
    return {1'b0, r.evict_action, r.evicted_page, r.evicted, r.granted_slot, r.status};
  endfunction

endpackage

`default_nettype wire

// File: rtl/cfr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module cfr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: rtl/cfr_scan.sv
// Lowest free slot below the limit within one chunk of eight slots.
`default_nettype none

module cfr_scan #(
  parameter int K_W   = 3,
  parameter int LIM_W = 7
) (
  input  wire logic [cfr_pkg::CHUNK-1:0] used_i,
  input  wire logic [K_W-1:0]            chunk_i,
  input  wire logic [LIM_W-1:0]          lim_i,
  output cfr_pkg::scan_res_t             res_o
);
  import cfr_pkg::*;

  localparam int IDX_W = K_W + 3;
  localparam int CMP_W = (IDX_W > LIM_W) ? IDX_W : LIM_W;

  logic [CHUNK-1:0] free_bits;

  always_comb begin
    logic [IDX_W-1:0] idx;
    for (int j = 0; j < CHUNK; j++) begin
      idx = {chunk_i, 3'(j)};
      free_bits[j] = !used_i[j] && (CMP_W'(idx) < CMP_W'(lim_i));
    end
  end

  // Walk from the top down so that the lowest free slot wins.
  always_comb begin
    res_o = '0;
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        res_o.found = 1'b1;
        res_o.pos   = 3'(j);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/clock_frame_replacement.sv
// Frame table with clock (second-chance) replacement: sequencer, slot table and result register.
//
// Usage: items arrive on the s_axis beat channel (op, frame_slot, page_tag, page_kind,
// is_write) and each produces exactly one result beat on m_axis (status, granted_slot,
// evicted, evicted_page, evict_action). The usable slot count is written through
// cfg_we_i / cfg_wdata_i; the user must write it only while the block is idle, which the
// block does not enforce. It is clamped to the table size. One item is worked on at a
// time; s_axis_tready is high only while the sequencer is idle. Pin, unpin and access
// pass through the execute and modify states, the last being a read-modify-write of the
// slot table RAM. Free, unknown ops and bad slots finish in the execute state.
// Alloc scans the used bits eight slots per cycle. With no free slot the clock hand then
// sweeps up to twice the usable count: an empty slot is passed over in the read state,
// while each occupied slot is read from the table RAM and evaluated in the next cycle.
// The result lands in an output register; a new item is accepted while it waits.
// If the receiver stalls with a result still held, the next item completes its work
// and then waits in its last step until the register frees.
// Reset clears the used bits, the hand and the pending result, and sets the limit to 64.
`default_nettype none

module clock_frame_replacement #(
  parameter int FRAMES   = cfr_pkg::FRAMES_DEF,
  parameter int TAG_BITS = cfr_pkg::TAG_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [cfr_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  // op[2:0], frame_slot[8:3], page_tag[28:9], page_kind[30:29], is_write[31]
  input  wire logic [cfr_pkg::DATA_W-1:0]   s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // status[1:0], granted_slot[7:2], evicted[8], evicted_page[28:9], evict_action[30:29]
  output logic      [cfr_pkg::DATA_W-1:0]   m_axis_tdata
);
  import cfr_pkg::*;

  localparam int SLOTS   = (FRAMES < MAX_SLOTS) ? FRAMES : MAX_SLOTS;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int LIM_W   = $clog2(SLOTS + 1);
  localparam int CHUNKS  = (SLOTS + CHUNK - 1) / CHUNK;
  localparam int K_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IDX_W   = K_W + 3;
  localparam int ENTRY_W = TAG_BITS + 12;

  // Table entry layout, from the lowest bit: page tag, kind, dirty, accessed, pin count.
  localparam int KIND_LO = TAG_BITS;
  localparam int DIRTY_B = TAG_BITS + 2;
  localparam int ACC_B   = TAG_BITS + 3;
  localparam int PIN_LO  = TAG_BITS + 4;

  state_e state_q, state_d;

  logic [LIMIT_W-1:0]  limit_q;
  logic [OP_W-1:0]     op_q;
  logic [SLOT_W_IO-1:0] slot_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [KIND_W-1:0]   kind_q;
  logic                wr_q;

  logic [SLOTS-1:0]    used_q, used_d;
  logic [SLOT_W-1:0]   hand_q, hand_d;
  logic [SLOT_W-1:0]   cur_q, cur_d;
  logic [LIM_W:0]      step_q, step_d;
  logic [K_W-1:0]      chunk_q, chunk_d;

  logic                m_valid_q;
  logic [DATA_W-1:0]   m_data_q;

  logic                in_fire;
  logic                out_free;
  logic                out_load;
  result_t             res;

  logic [LIM_W-1:0]    lim;
  logic [LIM_W:0]      two_lim;
  logic [SLOT_W-1:0]   slot_idx;
  logic                slot_ok;

  logic [SLOT_W-1:0]   sw_c;
  logic [SLOT_W-1:0]   sw_next;
  logic [LIM_W-1:0]    sw_c_inc;

  logic                ram_we;
  logic [SLOT_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [ENTRY_W-1:0]  grant_entry;
  logic [SLOT_W-1:0]   grant_idx;

  logic [CHUNK-1:0]    chunk_used;
  scan_res_t           scan_res;

  logic [7:0]          e_pin;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign lim      = (int'(limit_q) > SLOTS) ? LIM_W'(SLOTS) : LIM_W'(limit_q);
  assign two_lim  = {lim, 1'b0};
  assign slot_idx = slot_q[SLOT_W-1:0];
  assign slot_ok  = (int'(slot_q) < SLOTS) && used_q[slot_idx];

  // Hand position for this sweep step, restarting at slot 0 once past the limit.
  assign sw_c     = (LIM_W'(hand_q) >= lim) ? '0 : hand_q;
  assign sw_c_inc = LIM_W'(sw_c) + LIM_W'(1);
  assign sw_next  = (sw_c_inc >= lim) ? '0 : SLOT_W'(sw_c_inc);

  assign grant_entry = {8'd1, 1'b0, 1'b0, kind_q, tag_q};
  assign e_pin       = ram_rdata[PIN_LO +: 8];

  always_comb begin
    logic [IDX_W-1:0] idx;
    for (int j = 0; j < CHUNK; j++) begin
      idx = {chunk_q, 3'(j)};
      chunk_used[j] = (int'(idx) < SLOTS) ? used_q[idx[SLOT_W-1:0]] : 1'b1;
    end
  end

  cfr_scan #(
    .K_W   (K_W),
    .LIM_W (LIM_W)
  ) u_scan (
    .used_i  (chunk_used),
    .chunk_i (chunk_q),
    .lim_i   (lim),
    .res_o   (scan_res)
  );

  cfr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      limit_q <= FRAME_LIMIT_RST;
      used_q  <= '0;
      hand_q  <= '0;
      cur_q   <= '0;
      step_q  <= '0;
      chunk_q <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      hand_q  <= hand_d;
      cur_q   <= cur_d;
      step_q  <= step_d;
      chunk_q <= chunk_d;
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q   <= s_axis_tdata[2:0];
      slot_q <= s_axis_tdata[8:3];
      tag_q  <= TAG_BITS'(s_axis_tdata[28:9]);
      kind_q <= s_axis_tdata[30:29];
      wr_q   <= s_axis_tdata[31];
    end
    if (out_load) begin
      m_data_q <= pack_result(res);
    end
  end

  always_comb begin
    state_d   = state_q;
    used_d    = used_q;
    hand_d    = hand_q;
    cur_d     = cur_q;
    step_d    = step_q;
    chunk_d   = chunk_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = grant_entry;
    ram_raddr = cur_q;
    grant_idx = cur_q;
    out_load  = 1'b0;
    res       = '{status: STAT_OK, evict_action: ACT_NONE, default: '0};

    unique case (state_q)
      ST_IDLE: begin
        step_d  = '0;
        chunk_d = '0;
        if (in_fire) begin
          state_d = ST_EXEC;
        end
      end

      ST_EXEC: begin
        ram_raddr = slot_idx;
        unique case (op_q)
          OP_ALLOC: begin
            state_d = ST_SCAN;
          end
          OP_FREE, OP_PIN, OP_UNPIN, OP_ACCESS: begin
            if (!slot_ok) begin
              res.status = STAT_NOT_USED;
              if (out_free) begin
                out_load = 1'b1;
                state_d  = ST_IDLE;
              end
            end else if (op_q == OP_FREE) begin
              if (out_free) begin
                used_d[slot_idx] = 1'b0;
                out_load = 1'b1;
                state_d  = ST_IDLE;
              end
            end else begin
              state_d = ST_MODIFY;
            end
          end
          default: begin
            if (out_free) begin
              out_load = 1'b1;
              state_d  = ST_IDLE;
            end
          end
        endcase
      end

      ST_MODIFY: begin
        ram_raddr = slot_idx;
        ram_waddr = slot_idx;
        ram_wdata = ram_rdata;
        unique case (op_q)
          OP_PIN: begin
            if (e_pin != 8'hFF) begin
              ram_wdata[PIN_LO +: 8] = e_pin + 8'd1;
            end
          end
          OP_UNPIN: begin
            if (e_pin == 8'd0) begin
              res.status = STAT_UNPIN_ZERO;
            end else begin
              ram_wdata[PIN_LO +: 8] = e_pin - 8'd1;
            end
          end
          default: begin
            ram_wdata[ACC_B] = 1'b1;
            if (wr_q) begin
              ram_wdata[DIRTY_B] = 1'b1;
            end
          end
        endcase
        if (out_free) begin
          ram_we   = 1'b1;
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      ST_SCAN: begin
        grant_idx = SLOT_W'({chunk_q, scan_res.pos});
        if (scan_res.found) begin
          res.granted_slot = SLOT_W_IO'(grant_idx);
          if (out_free) begin
            ram_we    = 1'b1;
            ram_waddr = grant_idx;
            used_d[grant_idx] = 1'b1;
            out_load  = 1'b1;
            state_d   = ST_IDLE;
          end
        end else if (chunk_q == K_W'(CHUNKS - 1)) begin
          state_d = ST_SW_RD;
        end else begin
          chunk_d = chunk_q + K_W'(1);
        end
      end

      ST_SW_RD: begin
        if (step_q >= two_lim) begin
          res.status = STAT_NO_VICTIM;
          if (out_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end else begin
          ram_raddr = sw_c;
          cur_d     = sw_c;
          hand_d    = sw_next;
          step_d    = step_q + (LIM_W + 1)'(1);
          if (used_q[sw_c]) begin
            state_d = ST_SW_EV;
          end
        end
      end

      ST_SW_EV: begin
        if (e_pin != 8'd0) begin
          state_d = ST_SW_RD;
        end else if (ram_rdata[ACC_B]) begin
          // Second chance: clear the accessed mark and move on.
          ram_wdata        = ram_rdata;
          ram_wdata[ACC_B] = 1'b0;
          ram_we           = 1'b1;
          state_d          = ST_SW_RD;
        end else begin
          res.granted_slot = SLOT_W_IO'(cur_q);
          res.evicted      = 1'b1;
          res.evicted_page = TAG_W_IO'(ram_rdata[TAG_BITS-1:0]);
          res.evict_action = evict_action_f(ram_rdata[KIND_LO +: KIND_W], ram_rdata[DIRTY_B]);
          if (out_free) begin
            ram_we   = 1'b1;
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The hand only ever takes values below the table size.
  a_hand_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(hand_q) < SLOTS)
    else $error("clock hand beyond the slot table");

  // The sweep never runs past twice the usable count.
  a_step_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SW_RD || state_q == ST_SW_EV) |-> step_q <= two_lim)
    else $error("sweep step count beyond its bound");

  // A successful alloc leaves its granted slot marked in use.
  a_grant_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && op_q == OP_ALLOC && res.status == STAT_OK) |=> used_q[$past(grant_idx)])
    else $error("granted slot not marked in use");

  // An eviction is only reported by a successful alloc from the sweep.
  a_evict_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && res.evicted) |-> (res.status == STAT_OK && state_q == ST_SW_EV))
    else $error("eviction reported outside a successful sweep");

  // A result beat goes out only once per item, from a busy sequencer.
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (state_q != ST_IDLE && state_d == ST_IDLE))
    else $error("result produced without finishing an item");

endmodule

`default_nettype wire

// File: tb/sv/clock_frame_replacement_tb.sv
// Self-checking testbench for the clock frame replacement block, with a frame table scoreboard.
`timescale 1ns / 100ps

module clock_frame_replacement_tb;
  import cfr_pkg::*;

  localparam int          SLOTS         = MAX_SLOTS;
  localparam int          CYCLE_LIMIT   = 2000000;
  localparam int          HOLD_CYCLES   = 400;
  localparam int          DRAIN_CYCLES  = 300;
  localparam int          MAX_IDLE      = 16;
  localparam logic [2:0]  OP_RSVD_FIRST = 3'd5;
  localparam logic [2:0]  OP_RSVD_LAST  = 3'd7;
  localparam logic [1:0]  KIND_ANON     = 2'd0;
  localparam logic [1:0]  KIND_RSVD     = 2'd3;
  localparam logic [7:0]  PIN_MAX       = 8'd255;
  localparam logic [19:0] TAG_ALL_ONES  = 20'hFFFFF;

  typedef struct packed {
    logic        wr;
    logic [1:0]  kind;
    logic [19:0] tag;
    logic [5:0]  slot;
    logic [2:0]  op;
  } frame_req_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [19:0] page;
    logic        evicted;
    logic [5:0]  slot;
    logic [1:0]  status;
  } frame_res_t;

  // Mirror of the frame table; predicts one result beat per accepted request.
  class frame_table_sb;
    bit          used  [SLOTS];
    logic [7:0]  pins  [SLOTS];
    bit          acc   [SLOTS];
    bit          dirty [SLOTS];
    logic [1:0]  kind  [SLOTS];
    logic [19:0] page  [SLOTS];
    int unsigned hand;
    logic [6:0]  limit;
    frame_res_t  expected_q[$];
    int          mismatches;
    int          beats_seen;

    function new();
      limit = FRAME_LIMIT_RST;
      hand = 0;
      mismatches = 0;
      beats_seen = 0;
      foreach (used[i]) begin
        used[i] = 0;
        pins[i] = '0;
        acc[i] = 0;
        dirty[i] = 0;
        kind[i] = '0;
        page[i] = '0;
      end
    endfunction

    function int waiting();
      return expected_q.size();
    endfunction

    function void bind_slot(int unsigned c, frame_req_t r);
      used[c] = 1;
      pins[c] = 8'd1;
      acc[c] = 0;
      dirty[c] = 0;
      kind[c] = r.kind;
      page[c] = r.tag;
    endfunction

    function void note_item(frame_req_t r);
      frame_res_t  e;
      int unsigned lim;
      int unsigned c;
      int unsigned step;
      bit          found;
      e = '0;
      found = 0;
      lim = (limit > SLOTS) ? SLOTS : limit;
      case (r.op)
        OP_ALLOC: begin
          for (c = 0; c < lim; c++) begin
            if (!used[c]) begin
              bind_slot(c, r);
              e.slot = c[5:0];
              found = 1;
              break;
            end
          end
          if (!found) begin
            // Second-chance sweep; cleared marks and hand movement stay even if it fails.
            e.status = STAT_NO_VICTIM;
            for (step = 0; step < 2 * lim; step++) begin
              if (hand >= lim) hand = 0;
              c = hand;
              hand = (hand + 1 >= lim) ? 0 : hand + 1;
              if (!used[c] || pins[c] != 0) continue;
              if (acc[c]) begin
                acc[c] = 0;
                continue;
              end
              e.page = page[c];
              if (kind[c] == KIND_MMAP) begin
                e.action = dirty[c] ? ACT_WRITE_BACK : ACT_NONE;
              end else if (kind[c] == KIND_FILE && !dirty[c]) begin
                e.action = ACT_DISCARD;
              end else begin
                e.action = ACT_SWAP_OUT;
              end
              e.evicted = 1'b1;
              e.status = STAT_OK;
              e.slot = c[5:0];
              bind_slot(c, r);
              break;
            end
          end
        end
        OP_FREE, OP_PIN, OP_UNPIN, OP_ACCESS: begin
          if (!used[r.slot]) begin
            e.status = STAT_NOT_USED;
          end else if (r.op == OP_FREE) begin
            used[r.slot] = 0;
            pins[r.slot] = '0;
            acc[r.slot] = 0;
            dirty[r.slot] = 0;
          end else if (r.op == OP_PIN) begin
            if (pins[r.slot] != PIN_MAX) pins[r.slot] = pins[r.slot] + 8'd1;
          end else if (r.op == OP_UNPIN) begin
            if (pins[r.slot] == 0) e.status = STAT_UNPIN_ZERO;
            else pins[r.slot] = pins[r.slot] - 8'd1;
          end else begin
            acc[r.slot] = 1;
            if (r.wr) dirty[r.slot] = 1;
          end
        end
        default: ;
      endcase
      expected_q.push_back(e);
    endfunction

    task report(string msg);
      mismatches++;
      $display("mismatch: %s", msg);
    endtask

    task check_field(string name, int got, int want);
      if (got != want)
        report($sformatf("beat %0d %s got %0h expected %0h", beats_seen, name, got, want));
    endtask

    task check_result(logic [DATA_W-1:0] d);
      frame_res_t got;
      frame_res_t e;
      got = d[30:0];
      if (expected_q.size() == 0) begin
        report($sformatf("result %08h arrived with nothing expected", d));
      end else begin
        e = expected_q.pop_front();
        check_field("status", got.status, e.status);
        check_field("granted_slot", got.slot, e.slot);
        check_field("evicted", got.evicted, e.evicted);
        check_field("evicted_page", got.page, e.page);
        check_field("evict_action", got.action, e.action);
      end
      beats_seen++;
    endtask
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [LIMIT_W-1:0]   cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DATA_W-1:0]    m_axis_tdata;

  frame_table_sb sb;
  int            cycles = 0;
  bit            hold_req = 0;
  bit            src_calm = 0;
  bit            snk_calm = 0;

  clock_frame_replacement DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Idle stretches alternate with runs in which a side never waits.
  function automatic int draw_idle(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic frame_req_t mk(logic [2:0] op, logic [5:0] slot, logic [19:0] tag,
                                    logic [1:0] kind, logic wr);
    frame_req_t r;
    r.op = op;
    r.slot = slot;
    r.tag = tag;
    r.kind = kind;
    r.wr = wr;
    return r;
  endfunction

  // Mostly a slot that is in use, so that requests get past the slot check.
  function automatic logic [5:0] pick_slot();
    int start;
    int k;
    start = $urandom_range(0, SLOTS - 1);
    if ($urandom_range(0, 3) == 0) return start[5:0];
    for (k = 0; k < SLOTS; k++) begin
      if (sb.used[(start + k) % SLOTS]) return 6'((start + k) % SLOTS);
    end
    return start[5:0];
  endfunction

  function automatic frame_req_t random_item();
    frame_req_t r;
    int         w;
    w = $urandom_range(0, 99);
    if (w < 33) r.op = OP_ALLOC;
    else if (w < 40) r.op = OP_FREE;
    else if (w < 50) r.op = OP_PIN;
    else if (w < 73) r.op = OP_UNPIN;
    else if (w < 95) r.op = OP_ACCESS;
    else r.op = 3'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST));
    r.slot = pick_slot();
    r.tag = 20'($urandom);
    r.kind = 2'($urandom_range(0, 3));
    r.wr = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_item(frame_req_t r);
    int gap;
    gap = draw_idle(src_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, r};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_item(r);
    @(negedge clk_i);
  endtask

  task automatic end_phase();
    s_axis_tvalid <= 1'b0;
    while (sb.waiting() != 0) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.limit = v;
  endtask

  task automatic run_random(int n, bit with_hold);
    int i;
    for (i = 0; i < n; i++) begin
      if (with_hold && i == n / 2) hold_req = 1;
      send_item(random_item());
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int stall;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      stall = draw_idle(snk_calm);
      if (hold_req) begin
        hold_req = 0;
        stall = HOLD_CYCLES;
      end
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_result(m_axis_tdata);
      @(negedge clk_i);
    end
  end

  initial begin
    int phase_limit [8];
    int phase_len [8];
    int p;
    int o;
    int k;
    phase_limit = '{64, 4, 16, 1, 2, 8, 0, 127};
    phase_len = '{270, 90, 120, 60, 80, 110, 110, 120};
    phase_limit[6] = $urandom_range(2, 40);
    sb = new();
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // No usable slots: alloc cannot succeed; unknown ops change nothing.
    write_limit(7'd0);
    send_item(mk(OP_ALLOC, 6'd0, 20'd0, KIND_ANON, 1'b0));
    for (o = OP_RSVD_FIRST; o <= OP_RSVD_LAST; o++)
      send_item(mk(3'(o), 6'd63, TAG_ALL_ONES, KIND_RSVD, 1'b1));
    end_phase();

    // Three slots: fill, fail a sweep with everything pinned, then evict each kind.
    write_limit(7'd3);
    send_item(mk(OP_ALLOC, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, TAG_ALL_ONES, KIND_FILE, 1'b1));
    send_item(mk(OP_ALLOC, 6'd63, 20'h5A5A5, KIND_MMAP, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, 20'hA5A5A, KIND_RSVD, 1'b0));
    send_item(mk(OP_UNPIN, 6'd1, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_UNPIN, 6'd1, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_PIN, 6'd5, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ACCESS, 6'd1, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_UNPIN, 6'd2, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ACCESS, 6'd2, 20'd0, KIND_ANON, 1'b1));
    send_item(mk(OP_UNPIN, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, 20'h12345, KIND_MMAP, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, 20'h54321, KIND_FILE, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, 20'h0F0F0, KIND_ANON, 1'b0));
    send_item(mk(OP_UNPIN, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ALLOC, 6'd0, 20'h33333, KIND_FILE, 1'b0));
    send_item(mk(OP_FREE, 6'd1, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ACCESS, 6'd1, 20'd0, KIND_ANON, 1'b1));
    send_item(mk(OP_ACCESS, 6'd2, 20'd0, KIND_ANON, 1'b1));
    end_phase();

    // One slot: the hand lies beyond the limit, and slot 2 is in use beyond it.
    write_limit(7'd1);
    send_item(mk(OP_ALLOC, 6'd0, 20'h77777, KIND_MMAP, 1'b1));
    send_item(mk(OP_UNPIN, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_ACCESS, 6'd2, 20'd0, KIND_ANON, 1'b1));
    send_item(mk(OP_ALLOC, 6'd0, 20'h88888, KIND_FILE, 1'b0));
    end_phase();

    // Pin count saturation on slot 0, which the phase above left in use.
    write_limit(7'd127);
    for (k = 0; k < 260; k++) send_item(mk(OP_PIN, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_UNPIN, 6'd0, 20'd0, KIND_ANON, 1'b0));
    send_item(mk(OP_FREE, 6'd0, 20'd0, KIND_ANON, 1'b0));
    end_phase();

    for (p = 0; p < 8; p++) begin
      write_limit(7'(phase_limit[p]));
      run_random(phase_len[p], p == 1 || p == 2);
      end_phase();
    end

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (sb.mismatches == 0 && sb.waiting() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
